### rtl/dcpf_pkg.sv
// Shared types and constants for the display command packet framer.
// Depends on nothing; dcpf_front, dcpf_queue, dcpf_back and the top level import it.
package dcpf_pkg;

   localparam int unsigned HeaderBytes  = 16;
   localparam int unsigned ParamBytes   = 32;
   localparam int unsigned TrailerBytes = 4;

   // Length field offset added to the info byte count.
   localparam logic [15:0] LengthBase = 16'(HeaderBytes + ParamBytes + TrailerBytes);

   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 8;
   localparam logic [CsrIndexWidth-1:0] CsrHeaderByte = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrTailByte   = 1'b1;

   // Byte positions within one framed packet.
   localparam int unsigned PosWidth = 5;
   typedef logic [PosWidth-1:0] pos_type;

   localparam pos_type PosHeader  = 5'd0;
   localparam pos_type PosLenLo   = 5'd1;
   localparam pos_type PosLenHi   = 5'd2;
   localparam pos_type PosIdLo    = 5'd3;
   localparam pos_type PosIdHi    = 5'd4;
   localparam pos_type PosSeq0    = 5'd5;
   localparam pos_type PosSeq1    = 5'd6;
   localparam pos_type PosSeq2    = 5'd7;
   localparam pos_type PosSeq3    = 5'd8;
   localparam pos_type PosCmd     = 5'd13;
   localparam pos_type PosPayload = 5'd16;
   localparam pos_type PosSumLo   = 5'd17;
   localparam pos_type PosSumHi   = 5'd18;
   localparam pos_type PosTail    = 5'd20;

   // One classified input beat, as handed from the front end to the back end.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] packet_id;
      logic [7:0]  command_code;
      logic [15:0] length;
      logic [31:0] seq_num;
      logic        first;
      logic        last;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

### rtl/dcpf_if.sv
// Valid/ready channel interfaces for the packet framer's input and output beats.
// Depends on nothing beyond the language; widths follow the field definitions.
interface dcpf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [15:0] packet_id;
   logic [7:0]  command_code;
   logic [10:0] info_length;
   logic        end_of_payload;

   modport source (
      output valid, payload_byte, packet_id, command_code, info_length, end_of_payload,
      input  ready
   );
   modport sink (
      input  valid, payload_byte, packet_id, command_code, info_length, end_of_payload,
      output ready
   );
endinterface

interface dcpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       packet_last;

   modport source (
      output valid, out_byte, run_last, packet_last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, run_last, packet_last,
      output ready
   );
endinterface

### rtl/dcpf_front.sv
// Front end: accepts input beats, tracks packet boundaries and the sequence number.
// Depends on dcpf_pkg and dcpf_req_if; pushes one job per beat into the queue.
module dcpf_front (
   input  logic                      clock,
   input  logic                      reset,
   dcpf_req_if.sink                  req_bus,
   input  dcpf_pkg::queue_status_type q_status,
   output logic                      push,
   output dcpf_pkg::job_type         push_job
);
   import dcpf_pkg::*;

   logic        inside_ff, inside_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] seq_next;

   assign req_bus.ready = q_status.not_full;
   assign push          = req_bus.valid && q_status.not_full;
   assign seq_next      = seq_ff + 32'd1;

   always_comb begin
      inside_in = inside_ff;
      seq_in    = seq_ff;
      if (push) begin
         inside_in = !req_bus.end_of_payload;
         if (!inside_ff) begin
            seq_in = seq_next;
         end
      end
   end

   always_comb begin
      push_job.payload_byte = req_bus.payload_byte;
      push_job.packet_id    = req_bus.packet_id;
      push_job.command_code = req_bus.command_code;
      push_job.length       = LengthBase + 16'(req_bus.info_length);
      push_job.seq_num      = seq_next;
      push_job.first        = !inside_ff;
      push_job.last         = req_bus.end_of_payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         seq_ff    <= '0;
      end else begin
         inside_ff <= inside_in;
         seq_ff    <= seq_in;
      end
   end

endmodule

### rtl/dcpf_queue.sv
// Short job queue between the front and back ends of the packet framer.
// Depends on dcpf_pkg for the job type and queue depth.
module dcpf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcpf_pkg::job_type          push_job,
   input  logic                       pop,
   output dcpf_pkg::job_type          head_job,
   output dcpf_pkg::queue_status_type q_status
);
   import dcpf_pkg::*;

   job_type                  entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign head_job           = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.not_full  = (count_ff != QueueCntWidth'(QueueDepth));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/dcpf_back.sv
// Back end: walks each queued job through header, payload and trailer bytes.
// Depends on dcpf_pkg and dcpf_rsp_if; holds the byte registers and the checksum.
module dcpf_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [dcpf_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [dcpf_pkg::CsrDataWidth-1:0]        csr_wdata,
   input  dcpf_pkg::job_type                        head_job,
   input  dcpf_pkg::queue_status_type               q_status,
   output logic                                     pop,
   dcpf_rsp_if.source                               rsp_bus
);
   import dcpf_pkg::*;

   logic [7:0]  header_byte_ff;
   logic [7:0]  tail_byte_ff;
   pos_type     pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        run_last_ff;
   logic        packet_last_ff;

   pos_type     cur_pos;
   logic        advance;
   logic        emit;
   logic        job_done;
   logic [7:0]  byte_sel;

   // A job that continues a packet starts straight at the payload position.
   assign cur_pos  = (head_job.first || pos_ff != PosHeader) ? pos_ff : PosPayload;
   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = advance && q_status.not_empty;
   assign job_done = (cur_pos == PosTail) || (cur_pos == PosPayload && !head_job.last);
   assign pop      = emit && job_done;

   always_comb begin
      unique case (cur_pos)
         PosHeader:  byte_sel = header_byte_ff;
         PosLenLo:   byte_sel = head_job.length[7:0];
         PosLenHi:   byte_sel = head_job.length[15:8];
         PosIdLo:    byte_sel = head_job.packet_id[7:0];
         PosIdHi:    byte_sel = head_job.packet_id[15:8];
         PosSeq0:    byte_sel = head_job.seq_num[7:0];
         PosSeq1:    byte_sel = head_job.seq_num[15:8];
         PosSeq2:    byte_sel = head_job.seq_num[23:16];
         PosSeq3:    byte_sel = head_job.seq_num[31:24];
         PosCmd:     byte_sel = head_job.command_code;
         PosPayload: byte_sel = head_job.payload_byte;
         PosSumLo:   byte_sel = sum_ff[7:0];
         PosSumHi:   byte_sel = sum_ff[15:8];
         PosTail:    byte_sel = tail_byte_ff;
         default:    byte_sel = 8'h00;
      endcase
   end

   // The checksum stops growing after the payload byte, so both halves of the
   // trailer read the same total.
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (emit) begin
         pos_in = job_done ? PosHeader : cur_pos + 1'b1;
         if (cur_pos == PosHeader) begin
            sum_in = {8'h00, byte_sel};
         end else if (cur_pos <= PosPayload) begin
            sum_in = sum_ff + {8'h00, byte_sel};
         end
      end
      rsp_valid_in = advance ? q_status.not_empty : rsp_valid_ff;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_byte    = out_byte_ff;
   assign rsp_bus.run_last    = run_last_ff;
   assign rsp_bus.packet_last = packet_last_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff    <= byte_sel;
         run_last_ff    <= job_done;
         packet_last_ff <= (cur_pos == PosTail);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= 8'hA0;
         tail_byte_ff   <= 8'h50;
         pos_ff         <= PosHeader;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_index == CsrHeaderByte) begin
            header_byte_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CsrTailByte) begin
            tail_byte_ff <= csr_wdata;
         end
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/display_command_packet_framer.sv
// Display command packet framer: payload beats go in, framed packet bytes come out, one per beat.
// The first beat of a packet yields 17 output bytes (16-byte header and the byte itself), a
// middle beat one byte, and the last beat four more for the checksum, pad and tail bytes; a
// packet with a single beat gives 21. The output byte register is the only producer, so the
// sustained throughput is one output byte per cycle while rsp_bus.ready holds; input beats are
// taken at one per cycle while the four-entry job queue has room. An accepted beat is registered
// in the job queue, then in the output byte register. The registers (header byte, tail byte)
// must be written through the csr port while the block is idle; the block does not enforce it.
// Depends on dcpf_pkg, dcpf_if, dcpf_front, dcpf_queue and dcpf_back.
module display_command_packet_framer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dcpf_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [dcpf_pkg::CsrDataWidth-1:0]  csr_wdata,
   dcpf_req_if.sink                           req_bus,
   dcpf_rsp_if.source                         rsp_bus
);
   import dcpf_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;

   dcpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   dcpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   dcpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

### rtl/dcpf_checker.sv
// Port-level checks for the display command packet framer, bound to the top level.
// Depends only on the top level's ports.
module dcpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_packet_last
);

   // A stalled output beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_packet_last))
      else $error("output beat changed while stalled");

   // The tail byte always closes the run of its input beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_last |-> rsp_run_last)
      else $error("tail byte without run_last");

   // Nothing is offered in the cycle after a reset cycle.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind display_command_packet_framer dcpf_checker u_dcpf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_run_last    (rsp_bus.run_last),
   .rsp_packet_last (rsp_bus.packet_last)
);
